@@ rtl/core/olist_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg: shared constants and types for the ordered value list
// Sizes, operation and status codes, and the result record passed from the
// sequencer to the output register.
// ----------------------------------------------------------------------------
package olist_pkg;

  // List capacity and derived widths
  localparam int DEPTH    = 16;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] OP_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] OP_DUMP   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // One result transfer
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] entry;
    logic                     last;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/olist_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module olist_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/olist_obuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_obuf: result output register
// Holds one result until the downstream side takes it, so the sequencer can
// keep working while a result waits.
// ----------------------------------------------------------------------------
module olist_obuf
  import olist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  wire result_t                  res_in,
  output logic                          free,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic        [STATUS_W-1:0]    status,
  output logic        [POS_W-1:0]       position,
  output logic signed [DATA_W-1:0]      entry,
  output logic                          last
);

  logic    valid;
  result_t res;

  // Room for a new result when empty or when the held one leaves this cycle
  assign free = !valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

  assign out_valid = valid;
  assign status    = res.status;
  assign position  = res.position;
  assign entry     = res.entry;
  assign last      = res.last;

endmodule
`default_nettype wire

@@ rtl/core/olist_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_seq: operation sequencer
// Owns the entry count and walks the entry RAM: append on insert, linear
// scan on search/delete, read-shift-write on delete, in-order read on dump.
// ----------------------------------------------------------------------------
module olist_seq
  import olist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic        [KIND_W-1:0] kind,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          we,
  output logic             [ADDR_W-1:0] waddr,
  output logic             [DATA_W-1:0] wdata,
  output logic                          re,
  output logic             [ADDR_W-1:0] raddr,
  input  wire logic        [DATA_W-1:0] rdata,
  input  wire logic                     out_free,
  output logic                          res_load,
  output result_t                       res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DUMP   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]          state, state_next;
  logic [KIND_W-1:0]   op, op_next;
  logic [DATA_W-1:0]   val, val_next;
  logic [ADDR_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [POS_W-1:0]    res_pos, res_pos_next;

  logic [CNT_W-1:0]    idx_ext, idx_p1, idx_p2;
  logic                match;

  assign in_ready = (state == S_IDLE);
  assign idx_ext  = CNT_W'(idx);
  assign idx_p1   = idx_ext + CNT_W'(1);
  assign idx_p2   = idx_ext + CNT_W'(2);
  assign match    = (rdata == val);

  // Next-state and RAM control
  always_comb begin
    state_next      = state;
    op_next         = op;
    val_next        = val;
    idx_next        = idx;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    we              = 1'b0;
    waddr           = idx;
    wdata           = rdata;
    re              = 1'b0;
    raddr           = '0;
    res_load        = 1'b0;
    res             = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next    = kind;
          val_next   = value;
          state_next = S_START;
        end
      end
      S_START: begin
        idx_next     = '0;
        res_pos_next = '0;
        case (op)
          OP_INSERT: begin
            state_next = S_RESULT;
            if (cnt == CNT_W'(DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              we              = 1'b1;
              waddr           = cnt[ADDR_W-1:0];
              wdata           = val;
              cnt_next        = cnt + CNT_W'(1);
              res_status_next = ST_OK;
            end
          end
          OP_SEARCH, OP_DELETE: begin
            if (cnt == '0) begin
              res_status_next = (op == OP_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
              state_next      = S_RESULT;
            end else begin
              re         = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_RESULT;
            end else begin
              re         = 1'b1;
              state_next = S_DUMP;
            end
          end
        endcase
      end
      // rdata holds entry idx
      S_SCAN: begin
        if (match) begin
          if (op == OP_SEARCH) begin
            res_status_next = ST_OK;
            res_pos_next    = POS_W'(idx_p1);
            state_next      = S_RESULT;
          end else if (idx_p1 < cnt) begin
            re         = 1'b1;
            raddr      = idx_p1[ADDR_W-1:0];
            state_next = S_SHIFT;
          end else begin
            cnt_next        = cnt - CNT_W'(1);
            res_status_next = ST_OK;
            state_next      = S_RESULT;
          end
        end else if (idx_p1 < cnt) begin
          re       = 1'b1;
          raddr    = idx_p1[ADDR_W-1:0];
          idx_next = idx_p1[ADDR_W-1:0];
        end else begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_RESULT;
        end
      end
      // rdata holds entry idx+1; move it down one place
      S_SHIFT: begin
        we       = 1'b1;
        waddr    = idx;
        wdata    = rdata;
        idx_next = idx_p1[ADDR_W-1:0];
        if (idx_p2 < cnt) begin
          re    = 1'b1;
          raddr = idx_p2[ADDR_W-1:0];
        end else begin
          cnt_next        = cnt - CNT_W'(1);
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end
      // rdata holds entry idx; held until the output register takes it
      S_DUMP: begin
        if (out_free) begin
          res_load     = 1'b1;
          res.status   = ST_OK;
          res.entry    = rdata;
          res.last     = (idx_p1 == cnt);
          if (idx_p1 == cnt) begin
            state_next = S_IDLE;
          end else begin
            re       = 1'b1;
            raddr    = idx_p1[ADDR_W-1:0];
            idx_next = idx_p1[ADDR_W-1:0];
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          res_load     = 1'b1;
          res.status   = res_status;
          res.position = res_pos;
          res.last     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    val        <= val_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    re |-> (CNT_W'(raddr) < cnt))
    else $error("read of an entry beyond the count");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (idx_p1 < cnt))
    else $error("shift source beyond the count");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && op == OP_INSERT && cnt != CNT_W'(DEPTH))
    |=> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_delete_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && !(idx_p2 < cnt))
    |=> (cnt == $past(cnt) - CNT_W'(1)))
    else $error("delete did not shrink the list");

endmodule
`default_nettype wire

@@ rtl/core/ordered_list_insert_search_delete.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: insert and empty-list cases go through the start and result states to the
//   output register; search/delete scan one RAM entry per cycle, and a delete moves each
//   later entry down one per cycle after the match; dump streams one entry per cycle
//   while the output register is free.
// Throughput: one item at a time; the scan and shift rate is set by the single read port
//   of the entry RAM, and result back-pressure on the output register holds the
//   sequencer in its result and dump states; the next transfer is taken once idle.
// Reset: count cleared, list empty; entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
// ordered_list_insert_search_delete: ordered value list
// Insert at tail, search, delete with order kept, and dump, on a RAM-held list.
// ----------------------------------------------------------------------------
module ordered_list_insert_search_delete
  import olist_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic        [KIND_W-1:0]   kind,
  input  wire logic signed [DATA_W-1:0]   value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [STATUS_W-1:0] status,
  output logic             [POS_W-1:0]    position,
  output logic signed      [DATA_W-1:0]   entry,
  output logic                            last
);

  logic              we, re, res_load, out_free;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  result_t           res;

  // Entry storage
  olist_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Operation sequencer
  olist_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .value    (value),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  // Result register
  olist_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position),
    .entry     (entry),
    .last      (last)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ordered value list insert / search / delete / dump
// Sends list operations with random gaps while the result side applies random
// back-pressure. A shadow copy of the list predicts every result transfer, and
// each transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import olist_pkg::*;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic        [KIND_W-1:0]   kind      = OP_INSERT;
  logic signed [DATA_W-1:0]   value     = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic        [STATUS_W-1:0] status;
  logic        [POS_W-1:0]    position;
  logic signed [DATA_W-1:0]   entry;
  logic                       last;

  // Shadow list and the result transfers it predicts
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count = 0;
  result_t                  pending_results [$];
  int                       mismatch_count = 0;

  // Idle control: remaining no-idle run per side, receiver stall counter
  int send_run  = 0;
  int recv_run  = 0;
  int recv_hold = 0;

  ordered_list_insert_search_delete DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position),
    .entry     (entry),
    .last      (last)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Wait for one transfer: a random draw, or none during a no-idle run
  task automatic draw_wait(inout int run_left, output int cycles);
    if (run_left > 0) begin
      run_left--;
      cycles = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) run_left = $urandom_range(10, 40);
      cycles = $urandom_range(0, 18);
    end
  endtask

  function automatic void push_result(input logic [STATUS_W-1:0] st,
                                      input logic [POS_W-1:0] pos,
                                      input logic signed [DATA_W-1:0] ent,
                                      input logic lst);
    result_t r;
    r.status   = st;
    r.position = pos;
    r.entry    = ent;
    r.last     = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one operation to the shadow list and queue its results
  function automatic void apply_list_op(input logic [KIND_W-1:0] op,
                                        input logic signed [DATA_W-1:0] v);
    int hit;
    hit = shadow_count;
    for (int i = shadow_count - 1; i >= 0; i--)
      if (shadow_entries[i] == v) hit = i;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        if (hit < shadow_count) push_result(ST_OK, POS_W'(hit + 1), '0, 1'b1);
        else push_result(ST_NOTFOUND, '0, '0, 1'b1);
      end
      OP_DELETE: begin
        if (shadow_count == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else if (hit >= shadow_count) begin
          push_result(ST_NOTFOUND, '0, '0, 1'b1);
        end else begin
          // close the gap, order kept
          for (int i = hit; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      default: begin
        if (shadow_count == 0) push_result(ST_EMPTY, '0, '0, 1'b1);
        else
          for (int i = 0; i < shadow_count; i++)
            push_result(ST_OK, '0, shadow_entries[i], i + 1 == shadow_count);
      end
    endcase
  endfunction

  // Send one operation; valid stays high across back-to-back transfers
  task automatic send_op(input logic [KIND_W-1:0] op, input logic signed [DATA_W-1:0] v);
    int gap;
    draw_wait(send_run, gap);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind     <= op;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_list_op(op, v);
  endtask

  // Result side: stall drawn after each transfer
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      draw_wait(recv_run, recv_hold);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d position %0d entry %0d last %0d",
                                  status, position, entry, last));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", position, want.position));
        if (entry !== want.entry)
          report_mismatch($sformatf("entry %0d, want %0d", entry, want.entry));
        if (last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", last, want.last));
      end
    end
  end

  // Empty list: dump, search and delete all see no entries
  task automatic test_empty_list();
    send_op(OP_DUMP, $urandom);
    send_op(OP_SEARCH, '0);
    send_op(OP_DELETE, 32'h7FFF_FFFF);
  endtask

  // Fill with corner values and a duplicate, then insert when full and dump
  task automatic test_fill_to_full();
    logic signed [DATA_W-1:0] corner [7] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                             32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                                             32'hAAAA_AAAA};
    for (int i = 0; i < DEPTH; i++) begin
      if (i < 7) send_op(OP_INSERT, corner[i]);
      else if (i == 10) send_op(OP_INSERT, 32'h7FFF_FFFF);
      else send_op(OP_INSERT, $urandom);
    end
    send_op(OP_INSERT, 32'h0000_1234);
    send_op(OP_DUMP, $urandom);
  endtask

  // First-match search, misses, delete of a duplicate in the middle
  task automatic test_search_delete();
    send_op(OP_SEARCH, 32'h7FFF_FFFF);
    send_op(OP_SEARCH, 32'h0000_0002);
    send_op(OP_DELETE, 32'h0000_0002);
    send_op(OP_DELETE, 32'h7FFF_FFFF);
    send_op(OP_DUMP, $urandom);
  endtask

  // Random mix in phases that lean toward filling or draining the list
  task automatic test_random_traffic(input int total);
    logic signed [DATA_W-1:0] value_pool [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                                 32'hFFFF_FFFF, 32'h0000_0005, 32'h0F0F_F0F0};
    logic        [KIND_W-1:0] op;
    logic signed [DATA_W-1:0] v;
    int                       pick;
    bit                       filling;
    filling = 1'b1;
    for (int n = 0; n < total; n++) begin
      if (n % 40 == 0) filling = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 55 : 15)) op = OP_INSERT;
      else if (pick < (filling ? 72 : 35)) op = OP_SEARCH;
      else if (pick < 88) op = OP_DELETE;
      else op = OP_DUMP;
      // mostly values already held, so searches and deletes hit
      pick = $urandom_range(0, 9);
      if (shadow_count > 0 && pick < 6 && op != OP_INSERT)
        v = shadow_entries[$urandom_range(0, shadow_count - 1)];
      else if (pick < 8) v = value_pool[$urandom_range(0, 5)];
      else v = $urandom;
      send_op(op, v);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_to_full();
    test_search_delete();
    test_random_traffic(285);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
